### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define SSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define SSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ssr_pkg.sv
// Package: types, constants and helper functions of the SRRIP stream replacement block.
`default_nettype none
package ssr_pkg;

  localparam int NUM_SETS_DEF = 2048;
  localparam int NUM_WAYS_DEF = 16;
  localparam int SIG_BITS_DEF = 6;

  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int ADDR_W    = 48;
  localparam int SIG_IN_W  = 6;
  localparam int RED_W     = 28;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd2;
  localparam logic [1:0] RRPV_HIT  = 2'd0;
  localparam logic [1:0] REUSE_THR = 2'd2;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] LEVEL_MAX = 2'd2;
  localparam logic [ADDR_W:0] STRIDE = (ADDR_W+1)'(64);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED,
    ST_READ,
    ST_VIC,
    ST_UPD,
    ST_DEC,
    ST_DONE
  } state_t;

  // number of shifted-divisor steps needed to reduce an 11-bit set index
  function automatic int set_steps(input int n);
    int c;
    c = 0;
    for (int k = 0; k < SET_IN_W; k++) begin
      if ((n << k) <= ((1 << SET_IN_W) - 1)) c++;
    end
    return c;
  endfunction

  // way index modulo n, four narrow compare/subtract steps
  function automatic logic [WAY_IN_W-1:0] way_mod(input logic [WAY_IN_W-1:0] w, input int n);
    logic [WAY_IN_W+1:0] v;
    v = {2'b00, w};
    for (int k = WAY_IN_W - 1; k >= 0; k--) begin
      if (int'(v) >= (n << k)) v = v - (WAY_IN_W+2)'(n << k);
    end
    return v[WAY_IN_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/ssr_victim.sv
// Victim selection: ages a set's re-reference row and picks the lowest way at max.
`default_nettype none
module ssr_victim #(
  parameter int NUM_WAYS = ssr_pkg::NUM_WAYS_DEF,
  parameter int WAY_W    = $clog2(NUM_WAYS)
) (
  input  logic [NUM_WAYS*2-1:0] row,
  output logic [NUM_WAYS*2-1:0] aged,
  output logic [WAY_W-1:0]      way
);

  logic       any3;
  logic       any2;
  logic       any1;
  logic [1:0] top;
  logic [1:0] age;

  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (row[2*w +: 2] == ssr_pkg::RRPV_MAX);
      any2 = any2 | row[2*w+1];
      any1 = any1 | (row[2*w +: 2] != 2'd0);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    age = ssr_pkg::RRPV_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[2*w +: 2] = row[2*w +: 2] + age;
    end
    way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[2*w +: 2] == ssr_pkg::RRPV_MAX) way = WAY_W'(w);
    end
  end

endmodule
`default_nettype wire

### sv/ship_srrip_stream_replacement.sv
// Top level: SRRIP replacement with signature reuse counters and per-set stream detection.
// Sequence: set reduction by shifted-divisor subtraction, then read, modify, an optional
//   counter decrement for a miss with eviction, and result load.
// One word at a time: in_ready is high only in idle, so not during the set read-modify-write.
// Reset: rst clears control; a clearing pass over max(NUM_SETS, 2^SIG_BITS) addresses then
//   writes all memories to their reset contents, with no input word taken meanwhile.
`default_nettype none
module ship_srrip_stream_replacement #(
  parameter int NUM_SETS = ssr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = ssr_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS = ssr_pkg::SIG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [10:0] set_index,
  input  logic [3:0]  way_index,
  input  logic [47:0] address,
  input  logic [5:0]  signature,
  input  logic        hit,
  input  logic        victim_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  victim_way,
  output logic        streaming
);

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_ENT   = 1 << SIG_BITS;
  localparam int CLR_DEPTH = (NUM_SETS > SIG_ENT) ? NUM_SETS : SIG_ENT;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int STEPS     = ssr_pkg::set_steps(NUM_SETS);
  localparam int KTOP      = (STEPS > 0) ? STEPS - 1 : 0;
  localparam int ROW_RW    = NUM_WAYS * 2;
  localparam int ROW_SW    = NUM_WAYS * SIG_BITS;
  localparam int AW        = ssr_pkg::ADDR_W;
  localparam int STR_W     = AW + 2;
  localparam int RED_W_L   = ssr_pkg::RED_W;

  ssr_pkg::state_t state, state_next;

  logic [CLR_W-1:0]    clr;
  logic [3:0]          kcnt;
  logic [10:0]         r_set;
  logic                f_mode;
  logic [WAY_W-1:0]    f_way;
  logic [AW-1:0]       f_addr;
  logic [SIG_BITS-1:0] f_sig;
  logic                f_hit;
  logic                f_vic;
  logic [SIG_BITS-1:0] old_sig;
  logic [3:0]          res_way;
  logic                res_stream;

  logic [ROW_RW-1:0] rrpv_mem [NUM_SETS];
  logic [ROW_SW-1:0] sig_mem [NUM_SETS];
  logic [STR_W-1:0]  str_mem [NUM_SETS];
  logic [1:0]        reuse_mem [SIG_ENT];
  logic [ROW_RW-1:0] rrpv_q;
  logic [ROW_SW-1:0] sig_q;
  logic [STR_W-1:0]  str_q;
  logic [1:0]        reuse_q;

  logic                rd_en;
  logic [SET_W-1:0]    set_addr;
  logic                row_we;
  logic [SET_W-1:0]    row_wa;
  logic [ROW_RW-1:0]   rrpv_wd;
  logic [ROW_SW-1:0]   sig_wd;
  logic                sig_we;
  logic                str_we;
  logic [STR_W-1:0]    str_wd;
  logic                reuse_re;
  logic [SIG_BITS-1:0] reuse_ra;
  logic                reuse_we;
  logic [SIG_BITS-1:0] reuse_wa;
  logic [1:0]          reuse_wd;

  logic [AW-1:0]       prev;
  logic [1:0]          lvl;
  logic [1:0]          lvl_up;
  logic [1:0]          lvl_new;
  logic                stride_ok;
  logic                strm;
  logic [1:0]          ins;
  logic [SIG_BITS-1:0] cur_old_sig;
  logic [ROW_RW-1:0]   upd_row;
  logic [ROW_SW-1:0]   upd_sig;
  logic [ROW_RW-1:0]   aged_row;
  logic [WAY_W-1:0]    vway;
  logic [RED_W_L-1:0]  divisor;
  logic                load_out;

  ssr_victim #(
    .NUM_WAYS(NUM_WAYS),
    .WAY_W   (WAY_W)
  ) u_victim (
    .row (rrpv_q),
    .aged(aged_row),
    .way (vway)
  );

  assign set_addr = SET_W'(r_set);
  assign divisor  = RED_W_L'(NUM_SETS) << kcnt;
  assign in_ready = (state == ssr_pkg::ST_IDLE);
  assign load_out = (state == ssr_pkg::ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    prev      = str_q[AW-1:0];
    lvl       = str_q[STR_W-1:AW];
    stride_ok = ({1'b0, f_addr} == {1'b0, prev} + ssr_pkg::STRIDE) ||
                ({1'b0, prev} == {1'b0, f_addr} + ssr_pkg::STRIDE);
    lvl_up    = (lvl < ssr_pkg::LEVEL_MAX) ? lvl + 2'd1 : lvl;
    if (prev == '0) begin
      lvl_new = lvl;
    end else if (stride_ok) begin
      lvl_new = lvl_up;
    end else begin
      lvl_new = (lvl != 2'd0) ? lvl - 2'd1 : lvl;
    end
    strm = (prev != '0) && stride_ok && (lvl_up >= ssr_pkg::LEVEL_MAX);
    if (f_hit) begin
      ins = ssr_pkg::RRPV_HIT;
    end else if (strm) begin
      ins = ssr_pkg::RRPV_MAX;
    end else if (reuse_q >= ssr_pkg::REUSE_THR) begin
      ins = ssr_pkg::RRPV_HIT;
    end else begin
      ins = ssr_pkg::RRPV_NEAR;
    end
    cur_old_sig = sig_q[f_way*SIG_BITS +: SIG_BITS];
    upd_row = rrpv_q;
    upd_row[f_way*2 +: 2] = ins;
    upd_sig = sig_q;
    upd_sig[f_way*SIG_BITS +: SIG_BITS] = f_sig;
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    row_we     = 1'b0;
    row_wa     = set_addr;
    rrpv_wd    = upd_row;
    sig_we     = 1'b0;
    sig_wd     = upd_sig;
    str_we     = 1'b0;
    str_wd     = {lvl_new, f_addr};
    reuse_re   = 1'b0;
    reuse_ra   = f_sig;
    reuse_we   = 1'b0;
    reuse_wa   = f_sig;
    reuse_wd   = (reuse_q == ssr_pkg::CTR_MAX) ? reuse_q : reuse_q + 2'd1;
    case (state)
      ssr_pkg::ST_CLEAR: begin
        row_wa   = SET_W'(clr);
        row_we   = (32'(clr) < NUM_SETS);
        rrpv_wd  = '1;
        sig_we   = row_we;
        sig_wd   = '0;
        str_we   = row_we;
        str_wd   = '0;
        reuse_we = (32'(clr) < SIG_ENT);
        reuse_wa = SIG_BITS'(clr);
        reuse_wd = 2'd0;
        if (32'(clr) == CLR_DEPTH - 1) state_next = ssr_pkg::ST_IDLE;
      end
      ssr_pkg::ST_IDLE: begin
        if (in_valid) state_next = ssr_pkg::ST_RED;
      end
      ssr_pkg::ST_RED: begin
        if (kcnt == 4'd0) state_next = ssr_pkg::ST_READ;
      end
      ssr_pkg::ST_READ: begin
        rd_en      = 1'b1;
        reuse_re   = 1'b1;
        state_next = f_mode ? ssr_pkg::ST_UPD : ssr_pkg::ST_VIC;
      end
      ssr_pkg::ST_VIC: begin
        row_we     = 1'b1;
        rrpv_wd    = aged_row;
        state_next = ssr_pkg::ST_DONE;
      end
      ssr_pkg::ST_UPD: begin
        row_we = 1'b1;
        sig_we = !f_hit;
        str_we = 1'b1;
        if (f_hit) begin
          reuse_we   = 1'b1;
          state_next = ssr_pkg::ST_DONE;
        end else begin
          reuse_re   = 1'b1;
          reuse_ra   = cur_old_sig;
          state_next = f_vic ? ssr_pkg::ST_DEC : ssr_pkg::ST_DONE;
        end
      end
      ssr_pkg::ST_DEC: begin
        reuse_we   = (reuse_q != 2'd0);
        reuse_wa   = old_sig;
        reuse_wd   = reuse_q - 2'd1;
        state_next = ssr_pkg::ST_DONE;
      end
      ssr_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = ssr_pkg::ST_IDLE;
      end
      default: state_next = ssr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssr_pkg::ST_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ssr_pkg::ST_CLEAR) clr <= clr + CLR_W'(1);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_set  <= set_index;
      kcnt   <= 4'(KTOP);
      f_mode <= mode;
      f_way  <= WAY_W'(ssr_pkg::way_mod(way_index, NUM_WAYS));
      f_addr <= address;
      f_sig  <= SIG_BITS'(signature);
      f_hit  <= hit;
      f_vic  <= victim_valid;
    end
    if (state == ssr_pkg::ST_RED) begin
      if (RED_W_L'(r_set) >= divisor) r_set <= r_set - 11'(divisor);
      if (kcnt != 4'd0) kcnt <= kcnt - 4'd1;
    end
    if (state == ssr_pkg::ST_VIC) res_way <= 4'(vway);
    if (state == ssr_pkg::ST_UPD) begin
      res_stream <= strm;
      old_sig    <= cur_old_sig;
    end
    if (load_out) begin
      victim_way <= f_mode ? 4'd0 : res_way;
      streaming  <= f_mode ? res_stream : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) rrpv_mem[row_wa] <= rrpv_wd;
    if (sig_we) sig_mem[row_wa] <= sig_wd;
    if (str_we) str_mem[row_wa] <= str_wd;
    if (rd_en) begin
      rrpv_q <= rrpv_mem[set_addr];
      sig_q  <= sig_mem[set_addr];
      str_q  <= str_mem[set_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (reuse_we) reuse_mem[reuse_wa] <= reuse_wd;
    if (reuse_re) reuse_q <= reuse_mem[reuse_ra];
  end

endmodule
`default_nettype wire

### sv/ssr_checker.sv
// Port checker for the SRRIP stream replacement block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ssr_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] victim_way,
  input wire       streaming
);

  `SSR_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)
  `SSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(victim_way) && $stable(streaming))
  `SSR_ASSERT_NOW(a_stream_way, out_valid && streaming, victim_way == 4'd0)
  `SSR_ASSERT_NEXT(a_no_take_on_result, out_valid && !out_ready && !in_ready, !in_ready || !out_valid || out_ready)

endmodule

bind ship_srrip_stream_replacement ssr_checker u_ssr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .victim_way(victim_way),
  .streaming (streaming)
);
`default_nettype wire
